FILE: src/kst_pkg.sv
// ----------------------------------------------------------------------------
// kst_pkg
// Shared types, constants and the fixed keymap for the scancode translator.
// ----------------------------------------------------------------------------
`default_nettype none

package kst_pkg;

  localparam int KEYMAP_ROWS    = 96;
  localparam int KEY_CODE_COUNT = 128;
  localparam int ROW_W          = 7;
  localparam int CODE_W         = 7;
  localparam int BYTE_W         = 8;
  localparam int MAP_IDX_W      = $clog2(KEY_CODE_COUNT);

  localparam logic [BYTE_W-1:0] FN_ROW_MARK = 8'h80;

  typedef struct packed {
    logic [BYTE_W-1:0] norm;
    logic [CODE_W-1:0] func;
    logic [CODE_W-1:0] keypad;
  } keymap_row_t;

  typedef struct packed {
    logic              valid;
    logic [CODE_W-1:0] key_code;
    logic              key_pressed;
  } kst_result_t;

  function automatic keymap_row_t kst_keymap(input logic [ROW_W-1:0] row);
    keymap_row_t e;
    case (row)
      7'd0:    e = keymap_row_t'{8'd2,   7'd59,  7'd0};
      7'd1:    e = keymap_row_t'{8'd3,   7'd60,  7'd0};
      7'd2:    e = keymap_row_t'{8'd4,   7'd61,  7'd0};
      7'd3:    e = keymap_row_t'{8'd44,  7'd0,   7'd0};
      7'd4:    e = keymap_row_t'{8'd5,   7'd62,  7'd0};
      7'd5:    e = keymap_row_t'{8'd6,   7'd63,  7'd0};
      7'd6:    e = keymap_row_t'{8'd7,   7'd64,  7'd0};
      7'd7:    e = keymap_row_t'{8'd8,   7'd65,  7'd0};
      7'd8:    e = keymap_row_t'{FN_ROW_MARK, 7'd0, 7'd0};
      7'd9:    e = keymap_row_t'{8'd16,  7'd0,   7'd0};
      7'd10:   e = keymap_row_t'{8'd17,  7'd0,   7'd0};
      7'd11:   e = keymap_row_t'{8'd18,  7'd0,   7'd0};
      7'd12:   e = keymap_row_t'{8'd19,  7'd0,   7'd0};
      7'd13:   e = keymap_row_t'{8'd20,  7'd0,   7'd0};
      7'd14:   e = keymap_row_t'{8'd21,  7'd0,   7'd0};
      7'd15:   e = keymap_row_t'{8'd41,  7'd0,   7'd0};
      7'd16:   e = keymap_row_t'{8'd45,  7'd0,   7'd0};
      7'd17:   e = keymap_row_t'{8'd30,  7'd0,   7'd0};
      7'd18:   e = keymap_row_t'{8'd31,  7'd0,   7'd0};
      7'd19:   e = keymap_row_t'{8'd32,  7'd0,   7'd0};
      7'd20:   e = keymap_row_t'{8'd33,  7'd0,   7'd0};
      7'd21:   e = keymap_row_t'{8'd34,  7'd0,   7'd0};
      7'd22:   e = keymap_row_t'{8'd35,  7'd0,   7'd0};
      7'd23:   e = keymap_row_t'{8'd57,  7'd0,   7'd0};
      7'd24:   e = keymap_row_t'{8'd58,  7'd69,  7'd0};
      7'd25:   e = keymap_row_t'{8'd15,  7'd0,   7'd0};
      7'd26:   e = keymap_row_t'{8'd29,  7'd0,   7'd0};
      7'd35:   e = keymap_row_t'{8'd56,  7'd0,   7'd0};
      7'd44:   e = keymap_row_t'{8'd46,  7'd0,   7'd0};
      7'd45:   e = keymap_row_t'{8'd47,  7'd0,   7'd0};
      7'd46:   e = keymap_row_t'{8'd48,  7'd0,   7'd0};
      7'd47:   e = keymap_row_t'{8'd49,  7'd0,   7'd0};
      7'd48:   e = keymap_row_t'{8'd12,  7'd0,   7'd0};
      7'd49:   e = keymap_row_t'{8'd13,  7'd0,   7'd0};
      7'd50:   e = keymap_row_t'{8'd14,  7'd0,   7'd0};
      7'd51:   e = keymap_row_t'{8'd102, 7'd0,   7'd0};
      7'd52:   e = keymap_row_t'{8'd9,   7'd66,  7'd72};
      7'd53:   e = keymap_row_t'{8'd10,  7'd67,  7'd73};
      7'd54:   e = keymap_row_t'{8'd11,  7'd68,  7'd98};
      7'd55:   e = keymap_row_t'{8'd1,   7'd0,   7'd0};
      7'd56:   e = keymap_row_t'{8'd26,  7'd0,   7'd0};
      7'd57:   e = keymap_row_t'{8'd27,  7'd0,   7'd0};
      7'd58:   e = keymap_row_t'{8'd43,  7'd0,   7'd0};
      7'd59:   e = keymap_row_t'{8'd107, 7'd0,   7'd0};
      7'd60:   e = keymap_row_t'{8'd22,  7'd0,   7'd75};
      7'd61:   e = keymap_row_t'{8'd23,  7'd0,   7'd76};
      7'd62:   e = keymap_row_t'{8'd24,  7'd0,   7'd77};
      7'd63:   e = keymap_row_t'{8'd25,  7'd0,   7'd55};
      7'd64:   e = keymap_row_t'{8'd40,  7'd0,   7'd0};
      7'd65:   e = keymap_row_t'{8'd28,  7'd0,   7'd0};
      7'd66:   e = keymap_row_t'{8'd104, 7'd0,   7'd0};
      7'd68:   e = keymap_row_t'{8'd36,  7'd0,   7'd79};
      7'd69:   e = keymap_row_t'{8'd37,  7'd0,   7'd80};
      7'd70:   e = keymap_row_t'{8'd38,  7'd0,   7'd81};
      7'd71:   e = keymap_row_t'{8'd39,  7'd0,   7'd74};
      7'd72:   e = keymap_row_t'{8'd53,  7'd0,   7'd78};
      7'd73:   e = keymap_row_t'{8'd103, 7'd104, 7'd0};
      7'd74:   e = keymap_row_t'{8'd109, 7'd0,   7'd0};
      7'd76:   e = keymap_row_t'{8'd50,  7'd0,   7'd82};
      7'd77:   e = keymap_row_t'{8'd51,  7'd0,   7'd121};
      7'd78:   e = keymap_row_t'{8'd52,  7'd0,   7'd83};
      7'd79:   e = keymap_row_t'{8'd110, 7'd0,   7'd0};
      7'd80:   e = keymap_row_t'{8'd111, 7'd0,   7'd0};
      7'd81:   e = keymap_row_t'{8'd105, 7'd102, 7'd0};
      7'd82:   e = keymap_row_t'{8'd108, 7'd109, 7'd0};
      7'd83:   e = keymap_row_t'{8'd106, 7'd107, 7'd0};
      7'd88:   e = keymap_row_t'{8'd42,  7'd0,   7'd0};
      7'd89:   e = keymap_row_t'{8'd54,  7'd0,   7'd0};
      default: e = keymap_row_t'{8'd0,   7'd0,   7'd0};
    endcase
    return e;
  endfunction

endpackage

`default_nettype wire

FILE: src/kst_intf.sv
// ----------------------------------------------------------------------------
// kst_intf
// Valid/ready channels for scancodes, key events and the numlock register.
// ----------------------------------------------------------------------------
`default_nettype none

interface kst_rx_if import kst_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;
  logic              parity_error;
  logic              framing_error;

  modport source (output valid, rx_byte, parity_error, framing_error, input ready);
  modport sink   (input valid, rx_byte, parity_error, framing_error, output ready);
endinterface

interface kst_evt_if import kst_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] key_code;
  logic              key_pressed;

  modport source (output valid, key_code, key_pressed, input ready);
  modport sink   (input valid, key_code, key_pressed, output ready);
endinterface

interface kst_cfg_if ();
  logic valid;
  logic ready;
  logic numlock_on;

  modport source (output valid, numlock_on, input ready);
  modport sink   (input valid, numlock_on, output ready);
endinterface

`default_nettype wire

FILE: src/keyboard_scancode_translator.sv
// ----------------------------------------------------------------------------
// keyboard_scancode_translator
// Turns serial keyboard scancodes into key press and release events.
// ----------------------------------------------------------------------------
//   Channel  Direction  Payload
//   rx       in         rx_byte[7:0], parity_error, framing_error
//   evt      out        key_code[6:0], key_pressed
//   cfg      in         numlock_on
//
// One scancode is accepted per cycle unless the event output stalls; its event
// passes one input register and one result register before it is offered.
// Reset clears the held-function flag, the pressed-key map and numlock_on.
// A stalled event output stalls the input only when the waiting scancode
// would itself produce an event; dropped scancodes keep flowing.
// ----------------------------------------------------------------------------
`default_nettype none

module keyboard_scancode_translator import kst_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  kst_rx_if.sink    rx,
  kst_evt_if.source evt,
  kst_cfg_if.sink   cfg
);

  logic        numlock_on;
  logic        res_free;
  kst_result_t res;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      numlock_on <= 1'b0;
    end else if (cfg.valid && cfg.ready) begin
      numlock_on <= cfg.numlock_on;
    end
  end

  kst_xlate u_xlate (
    .clk      (clk),
    .rst      (rst),
    .in_valid (rx.valid),
    .in_ready (rx.ready),
    .in_byte  (rx.rx_byte),
    .in_error (rx.parity_error | rx.framing_error),
    .numlock  (numlock_on),
    .res_free (res_free),
    .res      (res)
  );

  kst_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .res      (res),
    .res_free (res_free),
    .evt      (evt)
  );

endmodule

`default_nettype wire

FILE: src/kst_xlate.sv
// ----------------------------------------------------------------------------
// kst_xlate
// Input register, keymap lookup, function/pressed state and event decision.
// ----------------------------------------------------------------------------
`default_nettype none

module kst_xlate import kst_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [BYTE_W-1:0] in_byte,
  input  wire logic              in_error,
  input  wire logic              numlock,
  input  wire logic              res_free,
  output kst_result_t            res
);

  logic                     stg_valid;
  logic [BYTE_W-1:0]        stg_byte;
  logic                     stg_error;
  logic                     function_held;
  logic [KEY_CODE_COUNT-1:0] pressed_map;

  logic [ROW_W-1:0]     row;
  logic                 down;
  logic                 in_range;
  keymap_row_t          entry;
  logic                 is_fn;
  logic [BYTE_W-1:0]    code;
  logic [MAP_IDX_W-1:0] idx;
  logic                 usable;
  logic                 emit;
  logic                 advance;

  always_comb begin
    row      = stg_byte[ROW_W-1:0];
    down     = ~stg_byte[BYTE_W-1];
    in_range = ({1'b0, row} < (ROW_W+1)'(KEYMAP_ROWS));
    entry    = kst_keymap(row);
    is_fn    = (entry.norm == FN_ROW_MARK);
    code     = entry.norm;
    if (numlock && (entry.keypad != '0)) begin
      code = {1'b0, entry.keypad};
    end
    if (function_held && (entry.func != '0)) begin
      code = {1'b0, entry.func};
    end
    idx     = code[MAP_IDX_W-1:0];
    usable  = stg_valid && !stg_error && in_range;
    emit    = usable && !is_fn && (code != '0) &&
              ({1'b0, code} < (BYTE_W+1)'(KEY_CODE_COUNT)) &&
              (pressed_map[idx] != down);
    advance = stg_valid && (!emit || res_free);
    in_ready = !stg_valid || advance;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid     <= 1'b0;
      function_held <= 1'b0;
      pressed_map   <= '0;
    end else begin
      if (in_valid && in_ready) begin
        stg_valid <= 1'b1;
      end else if (advance) begin
        stg_valid <= 1'b0;
      end
      if (advance && usable && is_fn) begin
        function_held <= down;
      end
      if (advance && emit) begin
        pressed_map[idx] <= down;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stg_byte  <= in_byte;
      stg_error <= in_error;
    end
  end

  always_comb begin
    res.valid       = emit && advance;
    res.key_code    = code[CODE_W-1:0];
    res.key_pressed = down;
  end

endmodule

`default_nettype wire

FILE: src/kst_out_reg.sv
// ----------------------------------------------------------------------------
// kst_out_reg
// Result register that holds one key event until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module kst_out_reg import kst_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  kst_result_t res,
  output logic       res_free,
  kst_evt_if.source  evt
);

  logic              valid;
  logic [CODE_W-1:0] key_code;
  logic              key_pressed;

  assign res_free = !valid || evt.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (res_free) begin
      valid <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_free && res.valid) begin
      key_code    <= res.key_code;
      key_pressed <= res.key_pressed;
    end
  end

  assign evt.valid       = valid;
  assign evt.key_code    = key_code;
  assign evt.key_pressed = key_pressed;

endmodule

`default_nettype wire

FILE: dv/kst_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kst_checker
// Watches the scancode, key event and numlock channels of the translator.
// It keeps its own keymap, held-function flag and pressed-key map, and
// predicts the key event, if any, of every scancode transfer. Each event transfer is
// compared in order with the oldest prediction.
// ----------------------------------------------------------------------------
module kst_checker import kst_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  kst_rx_if         rx,
  kst_evt_if        evt,
  kst_cfg_if        cfg,
  output int        errors,
  output int        outstanding
);

  typedef struct packed {
    logic [BYTE_W-1:0] norm;
    logic [CODE_W-1:0] func;
    logic [CODE_W-1:0] pad;
  } rom_row_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              pressed;
  } key_event_t;

  key_event_t                expected_events[$];
  key_event_t                oldest;
  logic [KEY_CODE_COUNT-1:0] keys_down;
  logic                      fn_down;
  logic                      numlock;
  int                        mismatch_count = 0;
  int                        pending_events = 0;

  assign errors      = mismatch_count;
  assign outstanding = pending_events;

  function automatic rom_row_t rom_row(input logic [ROW_W-1:0] row);
    rom_row_t e;
    case (row)
      7'd0:    e = {8'd2,   7'd59,  7'd0};
      7'd1:    e = {8'd3,   7'd60,  7'd0};
      7'd2:    e = {8'd4,   7'd61,  7'd0};
      7'd3:    e = {8'd44,  7'd0,   7'd0};
      7'd4:    e = {8'd5,   7'd62,  7'd0};
      7'd5:    e = {8'd6,   7'd63,  7'd0};
      7'd6:    e = {8'd7,   7'd64,  7'd0};
      7'd7:    e = {8'd8,   7'd65,  7'd0};
      7'd8:    e = {FN_ROW_MARK, 7'd0, 7'd0};
      7'd9:    e = {8'd16,  7'd0,   7'd0};
      7'd10:   e = {8'd17,  7'd0,   7'd0};
      7'd11:   e = {8'd18,  7'd0,   7'd0};
      7'd12:   e = {8'd19,  7'd0,   7'd0};
      7'd13:   e = {8'd20,  7'd0,   7'd0};
      7'd14:   e = {8'd21,  7'd0,   7'd0};
      7'd15:   e = {8'd41,  7'd0,   7'd0};
      7'd16:   e = {8'd45,  7'd0,   7'd0};
      7'd17:   e = {8'd30,  7'd0,   7'd0};
      7'd18:   e = {8'd31,  7'd0,   7'd0};
      7'd19:   e = {8'd32,  7'd0,   7'd0};
      7'd20:   e = {8'd33,  7'd0,   7'd0};
      7'd21:   e = {8'd34,  7'd0,   7'd0};
      7'd22:   e = {8'd35,  7'd0,   7'd0};
      7'd23:   e = {8'd57,  7'd0,   7'd0};
      7'd24:   e = {8'd58,  7'd69,  7'd0};
      7'd25:   e = {8'd15,  7'd0,   7'd0};
      7'd26:   e = {8'd29,  7'd0,   7'd0};
      7'd35:   e = {8'd56,  7'd0,   7'd0};
      7'd44:   e = {8'd46,  7'd0,   7'd0};
      7'd45:   e = {8'd47,  7'd0,   7'd0};
      7'd46:   e = {8'd48,  7'd0,   7'd0};
      7'd47:   e = {8'd49,  7'd0,   7'd0};
      7'd48:   e = {8'd12,  7'd0,   7'd0};
      7'd49:   e = {8'd13,  7'd0,   7'd0};
      7'd50:   e = {8'd14,  7'd0,   7'd0};
      7'd51:   e = {8'd102, 7'd0,   7'd0};
      7'd52:   e = {8'd9,   7'd66,  7'd72};
      7'd53:   e = {8'd10,  7'd67,  7'd73};
      7'd54:   e = {8'd11,  7'd68,  7'd98};
      7'd55:   e = {8'd1,   7'd0,   7'd0};
      7'd56:   e = {8'd26,  7'd0,   7'd0};
      7'd57:   e = {8'd27,  7'd0,   7'd0};
      7'd58:   e = {8'd43,  7'd0,   7'd0};
      7'd59:   e = {8'd107, 7'd0,   7'd0};
      7'd60:   e = {8'd22,  7'd0,   7'd75};
      7'd61:   e = {8'd23,  7'd0,   7'd76};
      7'd62:   e = {8'd24,  7'd0,   7'd77};
      7'd63:   e = {8'd25,  7'd0,   7'd55};
      7'd64:   e = {8'd40,  7'd0,   7'd0};
      7'd65:   e = {8'd28,  7'd0,   7'd0};
      7'd66:   e = {8'd104, 7'd0,   7'd0};
      7'd68:   e = {8'd36,  7'd0,   7'd79};
      7'd69:   e = {8'd37,  7'd0,   7'd80};
      7'd70:   e = {8'd38,  7'd0,   7'd81};
      7'd71:   e = {8'd39,  7'd0,   7'd74};
      7'd72:   e = {8'd53,  7'd0,   7'd78};
      7'd73:   e = {8'd103, 7'd104, 7'd0};
      7'd74:   e = {8'd109, 7'd0,   7'd0};
      7'd76:   e = {8'd50,  7'd0,   7'd82};
      7'd77:   e = {8'd51,  7'd0,   7'd121};
      7'd78:   e = {8'd52,  7'd0,   7'd83};
      7'd79:   e = {8'd110, 7'd0,   7'd0};
      7'd80:   e = {8'd111, 7'd0,   7'd0};
      7'd81:   e = {8'd105, 7'd102, 7'd0};
      7'd82:   e = {8'd108, 7'd109, 7'd0};
      7'd83:   e = {8'd106, 7'd107, 7'd0};
      7'd88:   e = {8'd42,  7'd0,   7'd0};
      7'd89:   e = {8'd54,  7'd0,   7'd0};
      default: e = '0;
    endcase
    return e;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic predict_key_event(input logic [BYTE_W-1:0] scan, input logic perr,
                                   input logic ferr);
    rom_row_t          entry;
    logic [BYTE_W-1:0] code;
    logic              down;
    entry = rom_row(scan[ROW_W-1:0]);
    down  = ~scan[7];
    if (perr || ferr) return;
    if (scan[ROW_W-1:0] >= KEYMAP_ROWS) return;
    if (entry.norm == FN_ROW_MARK) begin
      fn_down = down;
      return;
    end
    code = entry.norm;
    if (numlock && entry.pad != 0) code = {1'b0, entry.pad};
    if (fn_down && entry.func != 0) code = {1'b0, entry.func};
    if (code == 0 || code >= KEY_CODE_COUNT) return;
    if (keys_down[code[CODE_W-1:0]] == down) return;
    keys_down[code[CODE_W-1:0]] = down;
    expected_events.push_back(key_event_t'{code[CODE_W-1:0], down});
  endtask

  always @(posedge clk) begin
    if (rst) begin
      expected_events.delete();
      keys_down = '0;
      fn_down   = 1'b0;
      numlock   = 1'b0;
    end else begin
      if (evt.valid && evt.ready) begin
        if (expected_events.size() == 0) begin
          report_mismatch($sformatf("unexpected event code %0d pressed %0b",
                                    evt.key_code, evt.key_pressed));
        end else begin
          oldest = expected_events.pop_front();
          if (evt.key_code !== oldest.code)
            report_mismatch($sformatf("key_code %0d, predicted %0d",
                                      evt.key_code, oldest.code));
          if (evt.key_pressed !== oldest.pressed)
            report_mismatch($sformatf("key_pressed %0b for code %0d, predicted %0b",
                                      evt.key_pressed, oldest.code, oldest.pressed));
        end
      end
      if (rx.valid && rx.ready)
        predict_key_event(rx.rx_byte, rx.parity_error, rx.framing_error);
      if (cfg.valid && cfg.ready) numlock = cfg.numlock_on;
    end
    pending_events <= expected_events.size();
  end

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the keyboard scancode translator. A directed run covers the
// error flags, out-of-range and empty rows, repeated presses and releases,
// the function key and the numlock column; then random key sequences run
// under changing numlock settings and idling patterns on both channels.
// ----------------------------------------------------------------------------
module testbench import kst_pkg::*; ();

  localparam int STALL_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 4;
  localparam int HOLD_CYCLES  = 300;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   errors;
  int   outstanding;
  int   tx_idle_pct = 9;
  int   rx_idle_pct = 63;
  int   hold_count  = 0;
  int   hold_seen   = 0;
  int   hold_left   = 0;
  int   quiet_cycles = 0;
  int   held_rows[$];

  always #1 clk = ~clk;

  kst_rx_if  rx_ch ();
  kst_evt_if evt_ch ();
  kst_cfg_if cfg_ch ();

  keyboard_scancode_translator u_top (
    .clk (clk),
    .rst (rst),
    .rx  (rx_ch),
    .evt (evt_ch),
    .cfg (cfg_ch)
  );

  kst_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .rx          (rx_ch),
    .evt         (evt_ch),
    .cfg         (cfg_ch),
    .errors      (errors),
    .outstanding (outstanding)
  );

  // A new hold request starts a long stretch with the event output stalled.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      evt_ch.ready <= 1'b0;
    end else if (hold_count != hold_seen) begin
      hold_seen    <= hold_count;
      hold_left    <= HOLD_CYCLES;
      evt_ch.ready <= 1'b0;
    end else begin
      evt_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((rx_ch.valid && rx_ch.ready) || (evt_ch.valid && evt_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic send_scan(input logic [7:0] scan, input logic perr, input logic ferr);
    while ($urandom_range(99) < tx_idle_pct) begin
      rx_ch.valid         <= 1'b0;
      rx_ch.rx_byte       <= 8'($urandom_range(255));
      rx_ch.parity_error  <= 1'($urandom_range(1));
      rx_ch.framing_error <= 1'($urandom_range(1));
      @(posedge clk);
    end
    rx_ch.valid         <= 1'b1;
    rx_ch.rx_byte       <= scan;
    rx_ch.parity_error  <= perr;
    rx_ch.framing_error <= ferr;
    @(posedge clk);
    while (!rx_ch.ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    rx_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_numlock(input logic value);
    wait_drained();
    cfg_ch.valid      <= 1'b1;
    cfg_ch.numlock_on <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic bit row_is_mapped(input int row);
    return (row <= 26 && row != 8) || row == 35 || (row >= 44 && row <= 66) ||
           (row >= 68 && row <= 74) || (row >= 76 && row <= 83) || row == 88 ||
           row == 89;
  endfunction

  // Mostly press and release sequences of mapped keys, with function key
  // toggles, flagged bytes and arbitrary bytes mixed in.
  task automatic run_key_sequences(input int count);
    int  sent;
    int  pick;
    int  row;
    int  slot;
    logic perr;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        perr = 1'($urandom_range(1));
        send_scan(8'($urandom_range(255)), perr, perr ? 1'($urandom_range(1)) : 1'b1);
        sent++;
      end else if (pick < 16) begin
        send_scan(8'($urandom_range(255)), 1'b0, 1'b0);
        sent++;
      end else if (pick < 26) begin
        send_scan({1'($urandom_range(1)), 7'd8}, 1'b0, 1'b0);
        sent++;
      end else if (held_rows.size() > 0 && ($urandom_range(1) || held_rows.size() >= 8)) begin
        slot = $urandom_range(held_rows.size() - 1);
        row  = held_rows[slot];
        held_rows.delete(slot);
        send_scan({1'b1, row[6:0]}, 1'b0, 1'b0);
        sent++;
      end else begin
        do row = $urandom_range(KEYMAP_ROWS - 1); while (!row_is_mapped(row));
        held_rows.push_back(row);
        send_scan({1'b0, row[6:0]}, 1'b0, 1'b0);
        sent++;
      end
    end
  endtask

  initial begin
    rx_ch.valid         <= 1'b0;
    rx_ch.rx_byte       <= '0;
    rx_ch.parity_error  <= 1'b0;
    rx_ch.framing_error <= 1'b0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.numlock_on   <= 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    send_scan(8'h00, 1'b0, 1'b0);
    send_scan(8'h00, 1'b0, 1'b0);
    send_scan(8'h80, 1'b0, 1'b0);
    send_scan(8'h80, 1'b0, 1'b0);
    send_scan(8'h00, 1'b1, 1'b0);
    send_scan(8'h00, 1'b0, 1'b1);
    send_scan(8'hff, 1'b1, 1'b1);
    send_scan(8'h5f, 1'b0, 1'b0);
    send_scan(8'h60, 1'b0, 1'b0);
    send_scan(8'h7f, 1'b0, 1'b0);
    send_scan(8'hff, 1'b0, 1'b0);
    send_scan(8'h1b, 1'b0, 1'b0);
    send_scan(8'h08, 1'b0, 1'b0);
    send_scan(8'h00, 1'b0, 1'b0);
    send_scan(8'h88, 1'b1, 1'b0);
    send_scan(8'h80, 1'b0, 1'b0);
    send_scan(8'h88, 1'b0, 1'b0);

    write_numlock(1'b1);
    send_scan(8'h34, 1'b0, 1'b0);
    send_scan(8'h08, 1'b0, 1'b0);
    send_scan(8'h34, 1'b0, 1'b0);
    send_scan(8'hb4, 1'b0, 1'b0);
    send_scan(8'h88, 1'b0, 1'b0);
    send_scan(8'hb4, 1'b0, 1'b0);
    send_scan(8'h18, 1'b0, 1'b0);
    send_scan(8'h98, 1'b0, 1'b0);
    send_scan(8'h4d, 1'b0, 1'b0);
    send_scan(8'hcd, 1'b0, 1'b0);

    for (int phase = 0; phase < 6; phase++) begin
      case (phase / 2)
        0: begin
          tx_idle_pct <= 9;
          rx_idle_pct <= 63;
        end
        1: begin
          tx_idle_pct <= 63;
          rx_idle_pct <= 9;
        end
        default: begin
          tx_idle_pct <= 0;
          rx_idle_pct <= 0;
        end
      endcase
      write_numlock(phase[0]);
      run_key_sequences(150);
      if (phase == 4) begin
        hold_count <= hold_count + 1;
        run_key_sequences(40);
      end
    end

    wait_drained();
    if (errors == 0 && outstanding == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
